// ----- rtl/crlu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlu_pkg
// Shared types, constants and the saturation helper of the Crout LU unit.
// ----------------------------------------------------------------------------
package crlu_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic run_init;   // clear flags, preset determinant
        logic mat_rd;     // read matrix store
        logic lu_rd;      // read lower and upper stores
        logic clear_acc;
        logic mul_go;
        logic mul_det;    // multiply determinant by lower entry
        logic acc_go;
        logic diff_go;    // take overflow of the difference
        logic l_wr;
        logic piv_load;
        logic div_go;
        logic u_wr;
        logic u_zero;     // write zero to upper store
        logic det_go;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic piv_zero;
        logic div_done;
    } status_t;

    typedef struct packed {
        logic                ovf;
        logic [DATA_W-1:0]   val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] x);
        sat_t r;
        if (x > 64'sh0000_0000_7fff_ffff)
        begin
            r.ovf = 1'b1;
            r.val = 32'h7fff_ffff;
        end
        else if (x < -64'sh0000_0000_8000_0000)
        begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/crout_lu_determinant_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crout_lu_determinant_unit
// Crout LU factorization of a square Q16.16 matrix with its determinant.
//
//   Port group    Direction  Handshake            Carries
//   load          in         in_valid / in_stall   one matrix element
//   result        out        out_valid / out_stall one L/U position
//   config        in         APB                   matrix_size
//
// Loading takes one element per cycle while in_stall is low. After the
// element marked load_last, the unit computes column j of the lower factor,
// then row j of the upper factor in the bit-serial divider (zero when the
// pivot is zero), then the determinant, then emits each result. The load
// channel stalls from the last element until the final result transaction
// completes. Reset sets matrix_size to 4 and clears the internal flags.
// ----------------------------------------------------------------------------
module crout_lu_determinant_unit #(
    parameter int MAX_ORDER = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [$clog2(MAX_ORDER)-1:0]    row_index,
    input  logic [$clog2(MAX_ORDER)-1:0]    col_index,
    input  logic signed [31:0]              element_value,
    input  logic                            load_last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [$clog2(MAX_ORDER)-1:0]    out_row,
    output logic [$clog2(MAX_ORDER)-1:0]    out_col,
    output logic signed [31:0]              l_value,
    output logic signed [31:0]              u_value,
    output logic signed [31:0]              determinant,
    output logic                            singular,
    output logic                            overflow,
    output logic                            last_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import crlu_pkg::*;

    localparam int IDX_W = $clog2(MAX_ORDER);
    localparam int AW    = $clog2(MAX_ORDER * MAX_ORDER);
    localparam logic REG_MATRIX_SIZE = 1'b0;

    logic [2:0]    matrix_size_reg, matrix_size_next;
    logic          in_accept;
    logic          start;
    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] mat_addr;
    logic [AW-1:0] l_raddr;
    logic [AW-1:0] u_raddr;
    logic [AW-1:0] wr_addr;
    logic [IDX_W-1:0] pos_row;
    logic [IDX_W-1:0] pos_col;

    assign pready = 1'b1;

    always_comb
    begin
        matrix_size_next = matrix_size_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE)
            matrix_size_next = pwdata[2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matrix_size_reg <= 3'd4;
        else
            matrix_size_reg <= matrix_size_next;
    end

    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {29'd0, matrix_size_reg} : '0;

    assign in_accept = in_valid && !in_stall;
    assign start     = in_accept && load_last;

    crlu_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .matrix_size (matrix_size_reg),
        .start       (start),
        .in_stall    (in_stall),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .cmd         (cmd),
        .status      (status),
        .mat_addr    (mat_addr),
        .l_raddr     (l_raddr),
        .u_raddr     (u_raddr),
        .wr_addr     (wr_addr),
        .pos_row     (pos_row),
        .pos_col     (pos_col)
    );

    crlu_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .load_we     (in_accept),
        .load_row    (row_index),
        .load_col    (col_index),
        .load_value  (element_value),
        .mat_addr    (mat_addr),
        .l_raddr     (l_raddr),
        .u_raddr     (u_raddr),
        .wr_addr     (wr_addr),
        .pos_row     (pos_row),
        .pos_col     (pos_col),
        .out_row     (out_row),
        .out_col     (out_col),
        .l_value     (l_value),
        .u_value     (u_value),
        .determinant (determinant),
        .singular    (singular),
        .overflow    (overflow),
        .last_result (last_result)
    );

`ifndef SYNTH
    a_no_load_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("load channel open while a result is pending");

    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_result) |=> (!in_stall && !out_valid))
        else $error("load channel not reopened after final result");

    a_det_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> (determinant == 32'sd0))
        else $error("determinant on a result other than the last");

    a_unit_diagonal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_row == out_col) |-> (u_value == (32'sd1 <<< FRAC_BITS)))
        else $error("upper factor diagonal is not one");
`endif

endmodule

// ----- rtl/crlu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlu_div
// Restoring divider, one quotient bit a cycle: (num << FRAC_BITS) / den,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module crlu_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [crlu_pkg::DATA_W-1:0] num,
    input  logic [crlu_pkg::DATA_W-1:0] den,
    output logic                       done,
    output logic [crlu_pkg::DATA_W-1:0] quot,
    output logic                       ovf
);
    import crlu_pkg::*;

    localparam int DW = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [DATA_W:0]  rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W-1:0] neg_val;
    logic              ovf_pos;
    logic              ovf_neg;

    always_comb
    begin
        num_mag = num[DATA_W-1] ? (~num + 1'b1) : num;
        den_mag = den[DATA_W-1] ? (~den + 1'b1) : den;
        rem_sh  = {rem_reg[DATA_W-1:0], quo_reg[DW-1]};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW);
            neg_next  = num[DATA_W-1] ^ den[DATA_W-1];
            den_next  = den_mag;
            rem_next  = '0;
            quo_next  = {num_mag, {FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Saturate the magnitude against the signed range
    always_comb
    begin
        ovf_pos = |quo_reg[DW-1:DATA_W-1];
        ovf_neg = (|quo_reg[DW-1:DATA_W]) ||
                  (quo_reg[DATA_W-1] && (|quo_reg[DATA_W-2:0]));
        neg_val = ~quo_reg[DATA_W-1:0] + 1'b1;
        if (neg_reg)
        begin
            ovf  = ovf_neg;
            quot = ovf_neg ? 32'h8000_0000 : neg_val;
        end
        else
        begin
            ovf  = ovf_pos;
            quot = ovf_pos ? 32'h7fff_ffff : quo_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ----- rtl/crlu_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlu_datapath
// Matrix, lower and upper stores, multiply-accumulate, divider, determinant
// and the result register.
// ----------------------------------------------------------------------------
module crlu_datapath #(
    parameter int MAX_ORDER = 4,
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = $clog2(MAX_ORDER),
    parameter int AW        = $clog2(MAX_ORDER * MAX_ORDER)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  crlu_pkg::cmd_t              cmd,
    output crlu_pkg::status_t           status,
    input  logic                        load_we,
    input  logic [IDX_W-1:0]            load_row,
    input  logic [IDX_W-1:0]            load_col,
    input  logic [crlu_pkg::DATA_W-1:0] load_value,
    input  logic [AW-1:0]               mat_addr,
    input  logic [AW-1:0]               l_raddr,
    input  logic [AW-1:0]               u_raddr,
    input  logic [AW-1:0]               wr_addr,
    input  logic [IDX_W-1:0]            pos_row,
    input  logic [IDX_W-1:0]            pos_col,
    output logic [IDX_W-1:0]            out_row,
    output logic [IDX_W-1:0]            out_col,
    output logic signed [crlu_pkg::DATA_W-1:0] l_value,
    output logic signed [crlu_pkg::DATA_W-1:0] u_value,
    output logic signed [crlu_pkg::DATA_W-1:0] determinant,
    output logic                        singular,
    output logic                        overflow,
    output logic                        last_result
);
    import crlu_pkg::*;

    localparam int CELLS = MAX_ORDER * MAX_ORDER;
    localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W-1:0] mat_mem   [CELLS];
    logic signed [DATA_W-1:0] lower_mem [CELLS];
    logic signed [DATA_W-1:0] upper_mem [CELLS];

    logic signed [DATA_W-1:0] mat_rd_reg;
    logic signed [DATA_W-1:0] l_rd_reg;
    logic signed [DATA_W-1:0] u_rd_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] piv_reg;
    logic signed [DATA_W-1:0] det_reg;
    logic                     singular_reg, singular_next;
    logic                     overflow_reg, overflow_next;

    logic signed [WIDE_W-1:0] rounded;
    logic signed [WIDE_W-1:0] diff;
    sat_t                     diff_sat;
    sat_t                     det_sat;
    logic [DATA_W-1:0]        div_q;
    logic                     div_ovf;
    logic                     div_done;
    logic signed [DATA_W-1:0] u_wdata;
    logic                     load_in_range;

    assign load_in_range = ({1'b0, load_row} < (IDX_W + 1)'(MAX_ORDER)) &&
                           ({1'b0, load_col} < (IDX_W + 1)'(MAX_ORDER));

    // Matrix store: written by the load channel, read once per entry
    always_ff @(posedge clk)
    begin
        if (load_we && load_in_range)
            mat_mem[AW'(load_row) * AW'(MAX_ORDER) + AW'(load_col)] <= load_value;
        if (cmd.mat_rd)
            mat_rd_reg <= mat_mem[mat_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.l_wr)
            lower_mem[wr_addr] <= diff_sat.val;
        if (cmd.lu_rd)
            l_rd_reg <= lower_mem[l_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.u_wr)
            upper_mem[wr_addr] <= u_wdata;
        if (cmd.lu_rd)
            u_rd_reg <= upper_mem[u_raddr];
    end

    assign rounded  = (prod_reg + HALF) >>> FRAC_BITS;
    assign diff     = WIDE_W'(mat_rd_reg) - acc_reg;
    assign diff_sat = sat32(diff);
    assign det_sat  = sat32(rounded);
    assign u_wdata  = cmd.u_zero ? '0 : $signed(div_q);

    crlu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (diff_sat.val),
        .den   (piv_reg),
        .done  (div_done),
        .quot  (div_q),
        .ovf   (div_ovf)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            prod_reg <= cmd.mul_det ? WIDE_W'(det_reg) * WIDE_W'(l_rd_reg)
                                    : WIDE_W'(l_rd_reg) * WIDE_W'(u_rd_reg);
        if (cmd.clear_acc)
            acc_reg <= '0;
        else if (cmd.acc_go)
            acc_reg <= acc_reg + rounded;
        if (cmd.piv_load)
            piv_reg <= diff_sat.val;
        if (cmd.run_init)
            det_reg <= ONE;
        else if (cmd.det_go)
            det_reg <= det_sat.val;
    end

    always_comb
    begin
        singular_next = singular_reg;
        overflow_next = overflow_reg;
        if (cmd.run_init)
        begin
            singular_next = 1'b0;
            overflow_next = 1'b0;
        end
        else
        begin
            if (cmd.piv_load && diff_sat.val == '0)
                singular_next = 1'b1;
            if ((cmd.diff_go && diff_sat.ovf) ||
                (cmd.u_wr && !cmd.u_zero && div_ovf) ||
                (cmd.det_go && det_sat.ovf))
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            singular_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            singular_reg <= singular_next;
            overflow_reg <= overflow_next;
        end
    end

    // Result register: mask each factor to its triangle
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row     <= pos_row;
            out_col     <= pos_col;
            l_value     <= (pos_col <= pos_row) ? l_rd_reg : '0;
            if (pos_col > pos_row)
                u_value <= u_rd_reg;
            else if (pos_col == pos_row)
                u_value <= ONE;
            else
                u_value <= '0;
            determinant <= cmd.out_last ? det_reg : '0;
            singular    <= singular_reg;
            overflow    <= overflow_reg;
            last_result <= cmd.out_last;
        end
    end

    assign status.piv_zero = (piv_reg == '0);
    assign status.div_done = div_done;

endmodule

// ----- rtl/crlu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crlu_ctrl
// Sequencer: load, Crout column/row sweep, determinant, result emission.
// ----------------------------------------------------------------------------
module crlu_ctrl #(
    parameter int MAX_ORDER = 4,
    parameter int IDX_W     = $clog2(MAX_ORDER),
    parameter int AW        = $clog2(MAX_ORDER * MAX_ORDER)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [2:0]        matrix_size,
    input  logic              start,
    output logic              in_stall,
    input  logic              out_stall,
    output logic              out_valid,
    output crlu_pkg::cmd_t    cmd,
    input  crlu_pkg::status_t status,
    output logic [AW-1:0]     mat_addr,
    output logic [AW-1:0]     l_raddr,
    output logic [AW-1:0]     u_raddr,
    output logic [AW-1:0]     wr_addr,
    output logic [IDX_W-1:0]  pos_row,
    output logic [IDX_W-1:0]  pos_col
);
    import crlu_pkg::*;

    localparam int CW = $clog2(MAX_ORDER + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_ENTRY = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_ACC   = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_DACC  = 4'd9;
    localparam logic [3:0] S_ERD   = 4'd10;
    localparam logic [3:0] S_EOUT  = 4'd11;
    localparam logic [3:0] S_EWAIT = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic          phase_u_reg, phase_u_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] n;
    logic [CW-1:0] a_idx;
    logic [CW-1:0] b_idx;
    logic          i_more;
    logic          k_more;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_ORDER) + AW'(c);
    endfunction

    always_comb
    begin
        if (matrix_size == 3'd0)
            n = CW'(1);
        else if (32'(matrix_size) > MAX_ORDER)
            n = CW'(MAX_ORDER);
        else
            n = CW'(matrix_size);
    end

    // Lower phase works down column j, upper phase along row j
    assign a_idx  = phase_u_reg ? j_reg : i_reg;
    assign b_idx  = phase_u_reg ? i_reg : j_reg;
    assign i_more = (i_reg + CW'(1)) < n;
    assign k_more = (k_reg + CW'(1)) < n;

    assign mat_addr = addr_of(a_idx, b_idx);
    assign wr_addr  = addr_of(a_idx, b_idx);
    assign pos_row  = i_reg[IDX_W-1:0];
    assign pos_col  = k_reg[IDX_W-1:0];

    always_comb
    begin
        l_raddr = addr_of(a_idx, k_reg);
        u_raddr = addr_of(k_reg, b_idx);
        if (state_reg == S_DRD)
            l_raddr = addr_of(k_reg, k_reg);
        else if (state_reg == S_ERD)
        begin
            l_raddr = addr_of(i_reg, k_reg);
            u_raddr = addr_of(i_reg, k_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_u_next   = phase_u_reg;
        j_next         = j_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    cmd.run_init = 1'b1;
                    phase_u_next = 1'b0;
                    j_next       = '0;
                    i_next       = '0;
                    state_next   = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                cmd.mat_rd    = 1'b1;
                cmd.clear_acc = 1'b1;
                k_next        = '0;
                state_next    = (j_reg == '0) ? S_DIFF : S_RD;
            end
            S_RD:
            begin
                cmd.lu_rd  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_go = 1'b1;
                k_next     = k_reg + CW'(1);
                state_next = ((k_reg + CW'(1)) == j_reg) ? S_DIFF : S_RD;
            end
            S_DIFF:
            begin
                cmd.diff_go = 1'b1;
                if (!phase_u_reg)
                begin
                    cmd.l_wr     = 1'b1;
                    cmd.piv_load = (i_reg == j_reg);
                    if (i_more)
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_ENTRY;
                    end
                    else if ((j_reg + CW'(1)) < n)
                    begin
                        phase_u_next = 1'b1;
                        i_next       = j_reg + CW'(1);
                        state_next   = S_ENTRY;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_DRD;
                    end
                end
                else if (status.piv_zero)
                begin
                    cmd.u_wr   = 1'b1;
                    cmd.u_zero = 1'b1;
                    state_next = S_ENTRY;
                    if (i_more)
                        i_next = i_reg + CW'(1);
                    else
                    begin
                        j_next       = j_reg + CW'(1);
                        i_next       = j_reg + CW'(1);
                        phase_u_next = 1'b0;
                    end
                end
                else
                begin
                    cmd.div_go = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.u_wr   = 1'b1;
                    state_next = S_ENTRY;
                    if (i_more)
                        i_next = i_reg + CW'(1);
                    else
                    begin
                        j_next       = j_reg + CW'(1);
                        i_next       = j_reg + CW'(1);
                        phase_u_next = 1'b0;
                    end
                end
            end
            S_DRD:
            begin
                cmd.lu_rd  = 1'b1;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_det = 1'b1;
                state_next  = S_DACC;
            end
            S_DACC:
            begin
                cmd.det_go = 1'b1;
                if (k_more)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_DRD;
                end
                else
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_ERD;
                end
            end
            S_ERD:
            begin
                cmd.lu_rd  = 1'b1;
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = !i_more && !k_more;
                out_valid_next = 1'b1;
                state_next     = S_EWAIT;
            end
            S_EWAIT:
            begin
                // Hold the result until the transaction completes
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (k_more)
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = S_ERD;
                    end
                    else if (i_more)
                    begin
                        i_next     = i_reg + CW'(1);
                        k_next     = '0;
                        state_next = S_ERD;
                    end
                    else
                        state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next     = S_LOAD;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            phase_u_reg   <= 1'b0;
            j_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_u_reg   <= phase_u_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;

endmodule
